@@ hdl/http_request_head_parser_unit_assert.svh @@
// ----------------------------------------------------------------------------
// HTTP request head parser: assertion macros
// Shared concurrent assertion forms used by the parser modules.
// ----------------------------------------------------------------------------
`ifndef HTTP_REQUEST_HEAD_PARSER_UNIT_ASSERT_SVH
`define HTTP_REQUEST_HEAD_PARSER_UNIT_ASSERT_SVH

// Condition implies consequent in the same cycle
`define HRP_ASSERT_IMPLIES(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Condition implies consequent in the next cycle
`define HRP_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

@@ hdl/hrp_pkg.sv @@
// ----------------------------------------------------------------------------
// HTTP request head parser: package
// Result kinds, error codes, parser phases, job record and match tables.
// ----------------------------------------------------------------------------
package hrp_pkg;

    localparam int URI_BYTES_DEF  = 64;
    localparam int COUNT_BITS_DEF = 16;
    localparam int JOB_DEPTH      = 4;

    // Character codes
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3A;

    // Version field check
    localparam int VER_MIN_LEN = 8;
    localparam int VER_OFS     = 5;
    localparam int VER_LEN     = 3;

    typedef enum logic [2:0] {
        K_URI_BYTE = 3'd0,
        K_URI_DONE = 3'd1,
        K_HDR_DONE = 3'd2,
        K_REQ_DONE = 3'd3,
        K_ERROR    = 3'd4
    } t_kind;

    typedef enum logic [2:0] {
        E_BAD_METHOD = 3'd0,
        E_URI_LONG   = 3'd1,
        E_VER_SHORT  = 3'd2,
        E_EARLY_NL   = 3'd3,
        E_HEAD_LONG  = 3'd4
    } t_err;

    typedef enum logic [2:0] {
        PH_METHOD  = 3'd0,
        PH_URI     = 3'd1,
        PH_VERSION = 3'd2,
        PH_HKEY    = 3'd3,
        PH_HVAL    = 3'd4,
        PH_DONE    = 3'd5,
        PH_ERROR   = 3'd6
    } t_phase;

    typedef enum logic [1:0] {
        M_HEAD = 2'd0,
        M_GET  = 2'd1,
        M_POST = 2'd2
    } t_method;

    typedef enum logic [1:0] {
        BK_IDLE = 2'd0,
        BK_READ = 2'd1,
        BK_TAIL = 2'd2
    } t_bk_state;

    // One classified event from front to back
    typedef struct packed {
        t_kind       kind;
        logic [15:0] length;
        logic [15:0] value_length;
        logic [1:0]  method;
        logic        keepalive;
        logic [15:0] position;
        t_err        err;
    } t_job;

    // Method word bytes (HEAD, GET, POST)
    function automatic logic [7:0] word_byte(input logic [1:0] w, input logic [1:0] i);
        logic [7:0] c;
        c = 8'h00;
        unique case ({w, i})
            4'b00_00: c = "H";
            4'b00_01: c = "E";
            4'b00_10: c = "A";
            4'b00_11: c = "D";
            4'b01_00: c = "G";
            4'b01_01: c = "E";
            4'b01_10: c = "T";
            4'b10_00: c = "P";
            4'b10_01: c = "O";
            4'b10_10: c = "S";
            4'b10_11: c = "T";
            default:  c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [2:0] word_len(input logic [1:0] w);
        return (w == 2'd1) ? 3'd3 : 3'd4;
    endfunction

    // Expected version bytes "1.1"
    function automatic logic [7:0] ver_byte(input logic [1:0] k);
        return (k == 2'd1) ? 8'h2E : 8'h31;
    endfunction

endpackage

@@ hdl/hrp_ram.sv @@
// ----------------------------------------------------------------------------
// HTTP request head parser: generic RAM
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module hrp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read, holds when not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/hrp_job_fifo.sv @@
// ----------------------------------------------------------------------------
// HTTP request head parser: job queue
// Short first-in first-out queue of job records between front and back.
// ----------------------------------------------------------------------------
module hrp_job_fifo
    import hrp_pkg::*;
#(
    parameter int DEPTH = JOB_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output t_job o_head,
    output logic o_empty
);

    localparam int PW  = $clog2(DEPTH);
    localparam int CNW = $clog2(DEPTH + 1);

    t_job           r_mem [DEPTH];
    logic [PW-1:0]  r_wr, r_rd;
    logic [CNW-1:0] r_cnt;

    function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= ptr_next(r_wr);
            end
            if (i_pop) begin
                r_rd <= ptr_next(r_rd);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CNW'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - CNW'(1);
            end
        end
    end

    assign o_full  = (r_cnt == CNW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];

endmodule

@@ hdl/hrp_front.sv @@
// ----------------------------------------------------------------------------
// HTTP request head parser: front end
// Accepts bytes, tracks the parse phase and counters, stores URI bytes and
// queues one job for each byte that produces a result.
// ----------------------------------------------------------------------------
`include "http_request_head_parser_unit_assert.svh"

module hrp_front
    import hrp_pkg::*;
#(
    parameter int URI_BYTES  = URI_BYTES_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF,
    localparam int AW        = (URI_BYTES > 1) ? $clog2(URI_BYTES) : 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic          i_cmd,
    input  logic [7:0]    i_byte,
    input  logic          i_q_full,
    input  logic          i_run_done,
    output logic          o_push,
    output t_job          o_job,
    output logic          o_ram_we,
    output logic [AW-1:0] o_ram_waddr,
    output logic [7:0]    o_ram_wdata
);

    localparam int CW = COUNT_BITS;

    t_phase          r_phase, n_phase;
    logic [CW-1:0]   r_byte_cnt, n_byte_cnt;
    logic [CW-1:0]   r_tok_cnt, n_tok_cnt;
    logic [CW-1:0]   r_key_cnt, n_key_cnt;
    logic [2:0]      r_cand, n_cand;
    logic [2:0]      r_cand_done, n_cand_done;
    logic [1:0]      r_meth, n_meth;
    logic            r_ver_match, n_ver_match;
    logic            r_ver_done, n_ver_done;
    logic            r_keepalive, n_keepalive;
    logic            r_uri_busy, n_uri_busy;

    logic            acc;
    logic [7:0]      b;
    logic [CW-1:0]   ver_k;

    // Input stalls while a URI run is read back or the queue is full
    assign o_ready     = !i_q_full && !r_uri_busy;
    assign acc         = i_valid && o_ready;
    assign b           = (i_byte == CH_CR) ? 8'h00 : i_byte;
    assign ver_k       = r_tok_cnt - CW'(VER_OFS);
    assign o_ram_waddr = r_tok_cnt[AW-1:0];
    assign o_ram_wdata = b;

    // Parser state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_METHOD;
            r_byte_cnt  <= '0;
            r_tok_cnt   <= '0;
            r_key_cnt   <= '0;
            r_cand      <= 3'b111;
            r_cand_done <= '0;
            r_meth      <= '0;
            r_ver_match <= 1'b1;
            r_ver_done  <= 1'b0;
            r_keepalive <= 1'b0;
            r_uri_busy  <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_byte_cnt  <= n_byte_cnt;
            r_tok_cnt   <= n_tok_cnt;
            r_key_cnt   <= n_key_cnt;
            r_cand      <= n_cand;
            r_cand_done <= n_cand_done;
            r_meth      <= n_meth;
            r_ver_match <= n_ver_match;
            r_ver_done  <= n_ver_done;
            r_keepalive <= n_keepalive;
            r_uri_busy  <= n_uri_busy;
        end
    end

    // Next state and job classification
    always_comb begin
        n_phase     = r_phase;
        n_byte_cnt  = r_byte_cnt;
        n_tok_cnt   = r_tok_cnt;
        n_key_cnt   = r_key_cnt;
        n_cand      = r_cand;
        n_cand_done = r_cand_done;
        n_meth      = r_meth;
        n_ver_match = r_ver_match;
        n_ver_done  = r_ver_done;
        n_keepalive = r_keepalive;
        n_uri_busy  = r_uri_busy && !i_run_done;
        o_push      = 1'b0;
        o_job       = '0;
        o_ram_we    = 1'b0;

        if (acc) begin
            if (i_cmd) begin
                // restart for a new request
                n_phase     = PH_METHOD;
                n_byte_cnt  = '0;
                n_tok_cnt   = '0;
                n_key_cnt   = '0;
                n_cand      = 3'b111;
                n_cand_done = '0;
                n_meth      = '0;
                n_ver_match = 1'b1;
                n_ver_done  = 1'b0;
                n_keepalive = 1'b0;
            end else if (r_phase != PH_DONE && r_phase != PH_ERROR) begin
                n_byte_cnt = r_byte_cnt + CW'(1);
                priority if (r_byte_cnt == '1) begin
                    o_push    = 1'b1;
                    o_job.kind = K_ERROR;
                    o_job.err  = E_HEAD_LONG;
                    n_phase    = PH_ERROR;
                end else if (b == CH_SP && r_phase == PH_METHOD) begin
                    // first live candidate wins
                    priority if (r_cand[0]) begin
                        n_meth = M_HEAD;
                    end else if (r_cand[1]) begin
                        n_meth = M_GET;
                    end else if (r_cand[2]) begin
                        n_meth = M_POST;
                    end else begin
                        n_meth = r_meth;
                    end
                    if (r_cand == '0) begin
                        o_push     = 1'b1;
                        o_job.kind = K_ERROR;
                        o_job.err  = E_BAD_METHOD;
                        n_phase    = PH_ERROR;
                    end else begin
                        n_phase   = PH_URI;
                        n_tok_cnt = '0;
                    end
                end else if (b == CH_SP && r_phase == PH_URI) begin
                    if (r_tok_cnt >= CW'(URI_BYTES)) begin
                        o_push     = 1'b1;
                        o_job.kind = K_ERROR;
                        o_job.err  = E_URI_LONG;
                        n_phase    = PH_ERROR;
                    end else begin
                        o_push       = 1'b1;
                        o_job.kind   = K_URI_DONE;
                        o_job.length = 16'(r_tok_cnt);
                        n_uri_busy   = (r_tok_cnt != '0);
                        n_phase      = PH_VERSION;
                        n_tok_cnt    = '0;
                        n_ver_match  = 1'b1;
                        n_ver_done   = 1'b0;
                    end
                end else if (b == CH_LF) begin
                    priority if (r_phase == PH_METHOD || r_phase == PH_URI) begin
                        o_push     = 1'b1;
                        o_job.kind = K_ERROR;
                        o_job.err  = E_EARLY_NL;
                        n_phase    = PH_ERROR;
                    end else if (r_phase == PH_VERSION) begin
                        if (r_tok_cnt < CW'(VER_MIN_LEN)) begin
                            o_push     = 1'b1;
                            o_job.kind = K_ERROR;
                            o_job.err  = E_VER_SHORT;
                            n_phase    = PH_ERROR;
                        end else begin
                            n_keepalive = r_ver_match;
                            n_phase     = PH_HKEY;
                            n_tok_cnt   = '0;
                        end
                    end else if (r_phase == PH_HVAL) begin
                        o_push             = 1'b1;
                        o_job.kind         = K_HDR_DONE;
                        o_job.length       = 16'(r_key_cnt);
                        o_job.value_length = 16'(r_tok_cnt);
                        n_phase            = PH_HKEY;
                        n_tok_cnt          = '0;
                    end else begin
                        // line feed in the key phase ends the head
                        o_push          = 1'b1;
                        o_job.kind      = K_REQ_DONE;
                        o_job.method    = r_meth;
                        o_job.keepalive = r_keepalive;
                        o_job.position  = 16'(r_byte_cnt + CW'(1));
                        n_phase         = PH_DONE;
                    end
                end else if (b == CH_COLON && r_phase == PH_HKEY) begin
                    n_key_cnt = r_tok_cnt;
                    n_phase   = PH_HVAL;
                    n_tok_cnt = '0;
                end else begin
                    // ordinary token byte
                    if (r_phase == PH_METHOD) begin
                        for (int i = 0; i < 3; i++) begin
                            if (r_cand[i] && !r_cand_done[i]) begin
                                if (r_tok_cnt < CW'(word_len(2'(i)))) begin
                                    if (b != word_byte(2'(i), r_tok_cnt[1:0])) begin
                                        n_cand[i] = 1'b0;
                                    end
                                end else if (b == 8'h00) begin
                                    n_cand_done[i] = 1'b1;
                                end else begin
                                    n_cand[i] = 1'b0;
                                end
                            end
                        end
                    end else if (r_phase == PH_URI) begin
                        o_ram_we = (r_tok_cnt < CW'(URI_BYTES));
                    end else if (r_phase == PH_VERSION) begin
                        if (r_tok_cnt >= CW'(VER_OFS) && !r_ver_done && r_ver_match) begin
                            if (ver_k < CW'(VER_LEN)) begin
                                if (b != ver_byte(ver_k[1:0])) begin
                                    n_ver_match = 1'b0;
                                end
                            end else if (b == 8'h00) begin
                                n_ver_done = 1'b1;
                            end else begin
                                n_ver_match = 1'b0;
                            end
                        end
                    end
                    n_tok_cnt = r_tok_cnt + CW'(1);
                end
            end
        end
    end

    // Checks
    `HRP_ASSERT_IMPLIES(a_no_job_after_end, i_clk, i_rst_n,
        (r_phase == PH_DONE || r_phase == PH_ERROR), !o_push,
        "front queued a job after the request ended")
    `HRP_ASSERT_IMPLIES(a_uri_write_in_range, i_clk, i_rst_n,
        o_ram_we, (r_phase == PH_URI && r_tok_cnt < CW'(URI_BYTES)),
        "URI store written outside the URI token")

endmodule

@@ hdl/hrp_back.sv @@
// ----------------------------------------------------------------------------
// HTTP request head parser: back end
// Pops jobs, reads URI runs out of the store and drives the result register.
// ----------------------------------------------------------------------------
`include "http_request_head_parser_unit_assert.svh"

module hrp_back
    import hrp_pkg::*;
#(
    parameter int URI_BYTES = URI_BYTES_DEF,
    localparam int AW       = (URI_BYTES > 1) ? $clog2(URI_BYTES) : 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_job          i_head,
    input  logic          i_q_empty,
    output logic          o_pop,
    output logic          o_run_done,
    output logic          o_ram_re,
    output logic [AW-1:0] o_ram_raddr,
    input  logic [7:0]    i_ram_rdata,
    output logic          o_valid,
    input  logic          i_ready,
    output t_job          o_res,
    output logic [7:0]    o_res_byte,
    output logic          o_res_last
);

    t_bk_state     r_state, n_state;
    logic [AW-1:0] r_idx, n_idx;
    logic          r_out_valid, n_out_valid;
    t_job          r_out, n_out;
    logic [7:0]    r_out_byte, n_out_byte;
    logic          r_out_last, n_out_last;
    logic          out_free;

    assign out_free = !r_out_valid || i_ready;

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_out      <= n_out;
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
    end

    // Sequencer: single results pass through, URI runs read the store
    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_out_valid = r_out_valid && !i_ready;
        n_out       = r_out;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;
        o_pop       = 1'b0;
        o_run_done  = 1'b0;
        o_ram_re    = 1'b0;
        o_ram_raddr = r_idx;

        unique case (r_state)
            BK_IDLE: begin
                if (!i_q_empty && out_free) begin
                    if (i_head.kind == K_URI_DONE && i_head.length != '0) begin
                        o_ram_re    = 1'b1;
                        o_ram_raddr = '0;
                        n_idx       = '0;
                        n_state     = BK_READ;
                    end else begin
                        n_out_valid = 1'b1;
                        n_out       = i_head;
                        n_out_byte  = 8'h00;
                        n_out_last  = 1'b1;
                        o_pop       = 1'b1;
                    end
                end
            end
            BK_READ: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = '0;
                    n_out.kind  = K_URI_BYTE;
                    n_out_byte  = i_ram_rdata;
                    n_out_last  = 1'b0;
                    if (16'(r_idx) + 16'd1 == i_head.length) begin
                        n_state = BK_TAIL;
                    end else begin
                        o_ram_re    = 1'b1;
                        o_ram_raddr = r_idx + AW'(1);
                        n_idx       = r_idx + AW'(1);
                    end
                end
            end
            BK_TAIL: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = i_head;
                    n_out_byte  = 8'h00;
                    n_out_last  = 1'b1;
                    o_pop       = 1'b1;
                    o_run_done  = 1'b1;
                    n_state     = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    assign o_valid    = r_out_valid;
    assign o_res      = r_out;
    assign o_res_byte = r_out_byte;
    assign o_res_last = r_out_last;

    // Checks
    `HRP_ASSERT_IMPLIES(a_run_holds_job, i_clk, i_rst_n,
        (r_state != BK_IDLE), (!i_q_empty && i_head.kind == K_URI_DONE),
        "URI run active without its job at the queue head")
    `HRP_ASSERT_IMPLIES(a_last_on_single, i_clk, i_rst_n,
        (r_out_valid && r_out.kind != K_URI_BYTE), r_out_last,
        "non-byte result without last flag")
    `HRP_ASSERT_NEXT(a_tail_follows_run, i_clk, i_rst_n,
        (r_state == BK_READ && out_free && 16'(r_idx) + 16'd1 == i_head.length),
        (r_state == BK_TAIL && r_out_valid && r_out.kind == K_URI_BYTE),
        "last URI byte not followed by the run end")

endmodule

@@ hdl/http_request_head_parser_unit.sv @@
// Jobs pass through the job queue; every result leaves from the back end result register.
// Throughput: one byte per cycle while input is ready; a URI of N stored bytes holds
// input while the run is read from the URI store, one byte a cycle unless output stalls.
// Input also stalls when the 4-entry job queue is full.
// Reset: synchronous, active low; clears parser and queue state, not the URI store.
// ----------------------------------------------------------------------------
// HTTP request head parser: top level
// Front end classifies request bytes, a job queue decouples it from the back
// end that emits URI runs, header lengths, completion and errors.
// ----------------------------------------------------------------------------
module http_request_head_parser_unit
    import hrp_pkg::*;
#(
    parameter int URI_BYTES  = URI_BYTES_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,  // [7:0] data_byte
    input  logic        i_s_tuser,  // [0] cmd
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [7:0] out_byte, [23:8] length, [39:24] value_length, [41:40] method,
    // [42] keepalive, [58:43] position, [61:59] error_code, [63:62] zero
    output logic [63:0] o_m_tdata,
    output logic [2:0]  o_m_tuser,  // [2:0] kind
    output logic        o_m_tlast
);

    localparam int AW = (URI_BYTES > 1) ? $clog2(URI_BYTES) : 1;

    logic          q_full, q_empty, q_push, q_pop, run_done;
    t_job          push_job, head_job, res;
    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [7:0]    ram_wdata, ram_rdata, res_byte;

    // Classification front end
    hrp_front #(
        .URI_BYTES  (URI_BYTES),
        .COUNT_BITS (COUNT_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_tvalid),
        .o_ready     (o_s_tready),
        .i_cmd       (i_s_tuser),
        .i_byte      (i_s_tdata),
        .i_q_full    (q_full),
        .i_run_done  (run_done),
        .o_push      (q_push),
        .o_job       (push_job),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata)
    );

    // URI byte store
    hrp_ram #(
        .WIDTH (8),
        .DEPTH (URI_BYTES)
    ) u_uri_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Job queue
    hrp_job_fifo #(
        .DEPTH (JOB_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (push_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_head  (head_job),
        .o_empty (q_empty)
    );

    // Result back end
    hrp_back #(
        .URI_BYTES (URI_BYTES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head_job),
        .i_q_empty   (q_empty),
        .o_pop       (q_pop),
        .o_run_done  (run_done),
        .o_ram_re    (ram_re),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata),
        .o_valid     (o_m_tvalid),
        .i_ready     (i_m_tready),
        .o_res       (res),
        .o_res_byte  (res_byte),
        .o_res_last  (o_m_tlast)
    );

    // Result packing
    assign o_m_tdata = {2'b00, res.err, res.position, res.keepalive, res.method,
                        res.value_length, res.length, res_byte};
    assign o_m_tuser = res.kind;

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// HTTP request head parser: testbench
// Streams request heads into the parser byte by byte and checks every result
// transfer against a cycle-free software parser kept in step with the input.
// Directed heads cover each method, the URI, version and header rules and the
// error codes but the over-long head; the over-long URI is sent back to back.
// ----------------------------------------------------------------------------
module tb_top;
    import hrp_pkg::*;

    localparam int URI_MAX     = URI_BYTES_DEF;
    localparam int HEAD_MAX    = (1 << COUNT_BITS_DEF) - 1;
    localparam int QUIET_LIMIT = 5000;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN       = 16;

    // Method words and the expected version tail, first char in the top byte
    localparam logic [0:2][31:0] METHOD_TXT = {"HEAD", "GET ", "POST"};
    localparam logic [0:2][2:0]  METHOD_LEN = {3'd4, 3'd3, 3'd4};
    localparam logic [23:0]      VER_TXT    = "1.1";

    typedef struct packed {
        logic       cmd;
        logic [7:0] data;
        logic       rush;
    } t_head_byte;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  data;
        logic [15:0] len;
        logic [15:0] vlen;
        logic [1:0]  meth;
        logic        keep;
        logic [15:0] pos;
        logic [2:0]  err;
        logic        last;
    } t_head_result;

    logic        clk     = 1'b0;
    logic        rst_n   = 1'b0;
    logic        s_valid = 1'b0;
    logic [7:0]  s_data  = 8'h00;
    logic        s_user  = 1'b0;
    logic        s_ready;
    logic        m_valid;
    logic        m_ready;
    logic [63:0] m_data;
    logic [2:0]  m_user;
    logic        m_last;

    http_request_head_parser_unit dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_valid),
        .o_s_tready (s_ready),
        .i_s_tdata  (s_data),
        .i_s_tuser  (s_user),
        .o_m_tvalid (m_valid),
        .i_m_tready (m_ready),
        .o_m_tdata  (m_data),
        .o_m_tuser  (m_user),
        .o_m_tlast  (m_last)
    );

    always #10 clk = ~clk;

    // Stimulus and bookkeeping
    t_head_byte   stream_q[$];
    t_head_result due_results[$];
    t_head_result step_out[$];
    logic         rush_mode   = 1'b0;
    int           bytes_queued = 0;
    int           bytes_taken  = 0;
    int           results_seen = 0;
    int           mismatches   = 0;
    int           kind_cnt [5] = '{default: 0};
    logic [4:0]   err_mask     = '0;

    // Parser prediction state
    t_phase      req_phase;
    int          req_bytes;
    int          tok_len;
    int          key_len;
    logic [2:0]  meth_live;
    logic [2:0]  meth_ended;
    t_method     meth_pick;
    logic        ver_ok;
    logic        ver_ended;
    logic        keep_alive;
    logic [7:0]  uri_buf [URI_MAX];

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------
    function automatic void clear_parser();
        req_phase  = PH_METHOD;
        req_bytes  = 0;
        tok_len    = 0;
        key_len    = 0;
        meth_live  = 3'b111;
        meth_ended = 3'b000;
        meth_pick  = M_HEAD;
        ver_ok     = 1'b1;
        ver_ended  = 1'b0;
        keep_alive = 1'b0;
    endfunction

    function automatic t_head_result blank_of(input t_kind k);
        t_head_result r;
        r = '0;
        r.kind = k;
        return r;
    endfunction

    function automatic void raise_error(input t_err code);
        t_head_result r;
        r = blank_of(K_ERROR);
        r.err = code;
        step_out.push_back(r);
        req_phase = PH_ERROR;
    endfunction

    // Advance the parser by one accepted transfer and queue what it yields
    function automatic void parse_head_byte(input logic cmd, input logic [7:0] raw);
        logic [7:0]   c;
        t_head_result r;
        int           hit;
        int           k;
        step_out.delete();
        c = (raw == CH_CR) ? 8'h00 : raw;
        if (cmd) begin
            clear_parser();
        end else if (req_phase == PH_DONE || req_phase == PH_ERROR) begin
            // sticky: nothing until restart
        end else if (req_bytes >= HEAD_MAX) begin
            raise_error(E_HEAD_LONG);
        end else begin
            if (c == CH_SP && req_phase == PH_METHOD) begin
                hit = 3;
                for (int w = 2; w >= 0; w--)
                    if (meth_live[w]) hit = w;
                if (hit == 3) begin
                    raise_error(E_BAD_METHOD);
                end else begin
                    meth_pick = t_method'(hit);
                    req_phase = PH_URI;
                    tok_len   = 0;
                end
            end else if (c == CH_SP && req_phase == PH_URI) begin
                if (tok_len >= URI_MAX) begin
                    raise_error(E_URI_LONG);
                end else begin
                    for (int i = 0; i < tok_len; i++) begin
                        r = blank_of(K_URI_BYTE);
                        r.data = uri_buf[i];
                        step_out.push_back(r);
                    end
                    r = blank_of(K_URI_DONE);
                    r.len = tok_len[15:0];
                    step_out.push_back(r);
                    req_phase = PH_VERSION;
                    tok_len   = 0;
                    ver_ok    = 1'b1;
                    ver_ended = 1'b0;
                end
            end else if (c == CH_LF) begin
                case (req_phase)
                    PH_METHOD, PH_URI: raise_error(E_EARLY_NL);
                    PH_VERSION: begin
                        if (tok_len < VER_MIN_LEN) begin
                            raise_error(E_VER_SHORT);
                        end else begin
                            keep_alive = ver_ok;
                            req_phase  = PH_HKEY;
                            tok_len    = 0;
                        end
                    end
                    PH_HVAL: begin
                        r = blank_of(K_HDR_DONE);
                        r.len  = key_len[15:0];
                        r.vlen = tok_len[15:0];
                        step_out.push_back(r);
                        req_phase = PH_HKEY;
                        tok_len   = 0;
                    end
                    default: begin
                        // line feed in the key phase ends the head
                        r = blank_of(K_REQ_DONE);
                        r.meth = meth_pick;
                        r.keep = keep_alive;
                        r.pos  = 16'(req_bytes + 1);
                        step_out.push_back(r);
                        req_phase = PH_DONE;
                    end
                endcase
            end else if (c == CH_COLON && req_phase == PH_HKEY) begin
                key_len   = tok_len;
                req_phase = PH_HVAL;
                tok_len   = 0;
            end else begin
                // plain token byte
                if (req_phase == PH_METHOD) begin
                    for (int w = 0; w < 3; w++) begin
                        if (meth_live[w] && !meth_ended[w]) begin
                            if (tok_len < METHOD_LEN[w]) begin
                                if (c != METHOD_TXT[w][31 - 8*tok_len -: 8])
                                    meth_live[w] = 1'b0;
                            end else if (c == 8'h00) begin
                                meth_ended[w] = 1'b1;
                            end else begin
                                meth_live[w] = 1'b0;
                            end
                        end
                    end
                end else if (req_phase == PH_URI) begin
                    if (tok_len < URI_MAX) uri_buf[tok_len] = c;
                end else if (req_phase == PH_VERSION) begin
                    if (tok_len >= VER_OFS && !ver_ended && ver_ok) begin
                        k = tok_len - VER_OFS;
                        if (k < VER_LEN) begin
                            if (c != VER_TXT[23 - 8*k -: 8]) ver_ok = 1'b0;
                        end else if (c == 8'h00) begin
                            ver_ended = 1'b1;
                        end else begin
                            ver_ok = 1'b0;
                        end
                    end
                end
                tok_len++;
            end
            req_bytes++;
        end
        if (step_out.size() != 0) begin
            step_out[step_out.size() - 1].last = 1'b1;
            foreach (step_out[i]) due_results.push_back(step_out[i]);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic queue_byte(input logic cmd, input logic [7:0] b);
        t_head_byte it;
        it.cmd  = cmd;
        it.data = b;
        it.rush = rush_mode;
        stream_q.push_back(it);
        bytes_queued++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) queue_byte(1'b0, s[i]);
    endtask

    task automatic send_restart();
        queue_byte(1'b1, 8'($urandom_range(0, 255)));
    endtask

    // Random token byte: anything but space, line feed and colon
    function automatic logic [7:0] rand_tok();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 15) == 0) b = CH_CR;
        if (b == CH_SP || b == CH_LF || b == CH_COLON) b = "a";
        return b;
    endfunction

    // ------------------------------------------------------------------------
    // Sender: one transfer at a time, random gap before the next one
    // ------------------------------------------------------------------------
    int   tx_gap  = 0;
    logic tx_calm = 1'b0;

    always @(posedge clk) begin
        t_head_byte nxt;
        if (!rst_n) begin
            s_valid <= 1'b0;
            tx_gap  <= 0;
            clear_parser();
        end else if (!s_valid || s_ready) begin
            if (s_valid) begin
                parse_head_byte(s_user, s_data);
                bytes_taken++;
            end
            if (tx_gap != 0 || stream_q.size() == 0) begin
                s_valid <= 1'b0;
                if (tx_gap != 0) tx_gap <= tx_gap - 1;
            end else begin
                nxt = stream_q.pop_front();
                s_valid <= 1'b1;
                s_data  <= nxt.data;
                s_user  <= nxt.cmd;
                if ($urandom_range(0, 19) == 0) tx_calm <= !tx_calm;
                tx_gap <= (nxt.rush || tx_calm) ? 0 : $urandom_range(0, 8);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: random ready gaps plus one long hold-off
    // ------------------------------------------------------------------------
    logic rx_ready  = 1'b0;
    int   rx_gap    = 0;
    logic rx_calm   = 1'b0;
    int   hold_left = 0;
    logic hold_done = 1'b0;

    assign m_ready = rx_ready && (hold_left == 0);

    task automatic note_mismatch(input string what, input logic [15:0] want,
                                 input logic [15:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: result %0d: %s expected %0h, got %0h",
                     $time, results_seen, what, want, got);
    endtask

    task automatic check_result();
        t_head_result want;
        if (due_results.size() == 0) begin
            note_mismatch("kind (nothing due)", '0, m_user);
        end else begin
            want = due_results.pop_front();
            kind_cnt[want.kind]++;
            if (want.kind == K_ERROR) err_mask[want.err] = 1'b1;
            if (m_user !== want.kind)         note_mismatch("kind", want.kind, m_user);
            if (m_data[7:0] !== want.data)    note_mismatch("out_byte", want.data, m_data[7:0]);
            if (m_data[23:8] !== want.len)    note_mismatch("length", want.len, m_data[23:8]);
            if (m_data[39:24] !== want.vlen)
                note_mismatch("value_length", want.vlen, m_data[39:24]);
            if (m_data[41:40] !== want.meth)  note_mismatch("method", want.meth, m_data[41:40]);
            if (m_data[42] !== want.keep)     note_mismatch("keepalive", want.keep, m_data[42]);
            if (m_data[58:43] !== want.pos)   note_mismatch("position", want.pos, m_data[58:43]);
            if (m_data[61:59] !== want.err)   note_mismatch("error_code", want.err, m_data[61:59]);
            if (m_last !== want.last)         note_mismatch("last", want.last, m_last);
        end
    endtask

    always @(posedge clk) begin
        int draw;
        if (!rst_n) begin
            rx_ready <= 1'b0;
            rx_gap   <= 0;
        end else if (m_valid && m_ready) begin
            check_result();
            results_seen <= results_seen + 1;
            if ($urandom_range(0, 19) == 0) rx_calm <= !rx_calm;
            draw = rx_calm ? 0 : $urandom_range(0, 8);
            if (draw != 0) begin
                rx_ready <= 1'b0;
                rx_gap   <= draw;
            end
        end else if (!rx_ready) begin
            if (rx_gap <= 1) rx_ready <= 1'b1;
            else rx_gap <= rx_gap - 1;
        end
    end

    // Long hold-off once results are flowing, so the job queue backs up
    always @(posedge clk) begin
        if (!rst_n) begin
            hold_left <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && results_seen >= 30) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: too long without any transfer on either side
    // ------------------------------------------------------------------------
    int quiet = 0;

    always @(posedge clk) begin
        if (!rst_n || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("timeout: no transfer for %0d cycles, %0d results still due",
                     quiet, due_results.size());
            $display("status: fail");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------
    initial begin
        // Directed heads
        send_text("GET /index.html HTTP/1.1\015\nHost: x\015\n\015\n");
        send_text("zz");                               // ignored after done
        send_restart();
        send_text("HEAD / HTTP/1.0\n\n");
        send_restart();
        send_text("POST /f\015?a=1:2 HTTP/1.1\nK:\nk 2: v:w\n\n");
        send_restart();
        send_text("  HTTP/1.1\n\n");                   // empty method, empty URI
        send_restart();
        send_text("GET\015 /g HTTP/1.1 \n\n");         // method ended by CR, version tail
        send_restart();
        send_text("GE /p HTTP/1.1x\nab\n");            // method prefix, bad version tail
        send_restart();
        send_text("PUT / \n");                         // bad method, then sticky
        send_restart();
        send_text("GET /a\n");                         // newline inside the URI
        send_restart();
        send_text("\n");                               // newline inside the method
        send_restart();
        send_text("GET / HTTP/1\n");                   // version too short
        send_restart();
        rush_mode = 1'b1;
        send_text("POST ");                            // one byte too long
        repeat (URI_MAX) queue_byte(1'b0, rand_tok());
        send_text(" \n");
        rush_mode = 1'b0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (bytes_taken != bytes_queued) @(posedge clk);
        while (due_results.size() != 0) @(posedge clk);
        repeat (DRAIN) @(posedge clk);

        $display("covered %0d byte transfers and %0d results: %0d URI bytes, %0d URI runs,",
                 bytes_taken, results_seen, kind_cnt[K_URI_BYTE], kind_cnt[K_URI_DONE]);
        $display("%0d headers, %0d finished heads, %0d errors (codes seen %b), %0d mismatches",
                 kind_cnt[K_HDR_DONE], kind_cnt[K_REQ_DONE], kind_cnt[K_ERROR],
                 err_mask, mismatches);
        if (mismatches == 0 && due_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

@@ http_request_head_parser_unit.f @@
+incdir+hdl
hdl/hrp_pkg.sv
hdl/hrp_ram.sv
hdl/hrp_job_fifo.sv
hdl/hrp_front.sv
hdl/hrp_back.sv
hdl/http_request_head_parser_unit.sv
bench/tb_top.sv
